// ===== src/dfse_pkg.sv =====
// Package for the decimal field slot encoder.
// Holds the slot constants and the encoder result type; no dependencies.
`default_nettype none

package dfse_pkg;

  // Precision at or below this keeps the value inline in the slot
  localparam logic [5:0] INLINE_MAX_PRECISION = 6'd18;
  // Precision after reset
  localparam logic [5:0] PRECISION_RESET = 6'd38;
  // Bytes reserved in the variable area for one wide decimal
  localparam logic [16:0] WIDE_SLOT_BYTES = 17'd16;
  // Bit position of the cursor within the slot word
  localparam int CURSOR_SHIFT = 32;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 216;

  // Wide encoder result: byte count and left-aligned big-endian bytes
  typedef struct packed {
    logic [4:0]   count;
    logic [127:0] bytes;
  } wide_enc_t;

endpackage

`default_nettype wire

// ===== src/decimal_field_slot_encoder.sv =====
// Top level of the decimal field slot encoder: input register, encoder, result register.
// Depends on dfse_pkg and dfse_wide_enc.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: value_high, value_low, cursor; tuser: is_null
//  m_axis    out  m_axis_tvalid/tready       tdata: slot_word .. next_cursor; tuser: null_flag
//  cfg       in   cfg_valid/cfg_ready        cfg_data: precision
//
// Input register feeds result register; one item per cycle while the output is not stalled.
// The limit is the single pass through the byte-length search and byte shifter.
// rst (synchronous, active high) empties both stages and sets precision to 38.
// A stalled output holds its result; the input stage still fills behind it.
`default_nettype none

module decimal_field_slot_encoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // {cursor[143:128], value_low[127:64], value_high[63:0]}
  input  wire logic [dfse_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // {is_null}
  input  wire logic                            s_axis_tuser,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // {pad[215:214], next_cursor[213:197], bytes_lower[196:133],
  //  bytes_upper[132:69], byte_count[68:64], slot_word[63:0]}
  output logic [dfse_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // {null_flag}
  output logic                                 m_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [5:0]                      cfg_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready
);
  import dfse_pkg::*;

  logic [5:0]  precision;

  // Input stage
  logic        in_valid;
  logic [63:0] in_high;
  logic [63:0] in_low;
  logic        in_null;
  logic [15:0] in_cursor;

  // Result stage
  logic        out_valid;
  logic [63:0] slot_word;
  logic [4:0]  byte_count;
  logic [63:0] bytes_upper;
  logic [63:0] bytes_lower;
  logic [16:0] next_cursor;
  logic        null_flag;

  logic        out_load;
  logic        in_load;

  logic        wide;
  wide_enc_t   enc;
  logic [63:0] slot_word_next;
  logic [4:0]  byte_count_next;
  logic [63:0] bytes_upper_next;
  logic [63:0] bytes_lower_next;
  logic [16:0] next_cursor_next;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= PRECISION_RESET;
    end else if (cfg_valid) begin
      precision <= cfg_data;
    end
  end

  // Stage flow control
  assign out_load      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_high   <= s_axis_tdata[63:0];
      in_low    <= s_axis_tdata[127:64];
      in_cursor <= s_axis_tdata[143:128];
      in_null   <= s_axis_tuser;
    end
  end

  dfse_wide_enc u_wide_enc (
    .value_high (in_high),
    .value_low  (in_low),
    .enc        (enc)
  );

  // Slot formation
  assign wide = precision > INLINE_MAX_PRECISION;

  always_comb begin
    slot_word_next   = 64'd0;
    byte_count_next  = 5'd0;
    bytes_upper_next = 64'd0;
    bytes_lower_next = 64'd0;
    next_cursor_next = {1'b0, in_cursor};
    if (wide) begin
      next_cursor_next = {1'b0, in_cursor} + WIDE_SLOT_BYTES;
    end
    if (!in_null) begin
      if (wide) begin
        slot_word_next   = ({48'd0, in_cursor} << CURSOR_SHIFT) | {59'd0, enc.count};
        byte_count_next  = enc.count;
        bytes_upper_next = enc.bytes[127:64];
        bytes_lower_next = enc.bytes[63:0];
      end else begin
        slot_word_next = in_low;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      slot_word   <= slot_word_next;
      byte_count  <= byte_count_next;
      bytes_upper <= bytes_upper_next;
      bytes_lower <= bytes_lower_next;
      next_cursor <= next_cursor_next;
      null_flag   <= in_null;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = null_flag;
  assign m_axis_tdata  = {2'b00, next_cursor, bytes_lower, bytes_upper, byte_count, slot_word};

endmodule

`default_nettype wire

// ===== src/dfse_wide_enc.sv =====
// Minimal two's-complement byte string encoder for a 128-bit value.
// Combinational; uses dfse_pkg for the result type.
`default_nettype none

module dfse_wide_enc (
  input  wire logic [63:0]      value_high,
  input  wire logic [63:0]      value_low,
  output dfse_pkg::wide_enc_t   enc
);
  import dfse_pkg::*;

  logic [127:0] value;
  logic [127:0] mag;
  logic [15:0]  fits;
  logic [4:0]   count;
  logic [3:0]   shift_bytes;
  logic [127:0] shifted;

  // Magnitude for bit length: complement of negative values
  assign value = {value_high, value_low};
  assign mag   = value[127] ? ~value : value;

  // n bytes suffice when the magnitude is below 2^(8n-1)
  always_comb begin
    for (int n = 1; n <= 16; n++) begin
      fits[n-1] = ((mag >> (8 * n - 1)) == 128'd0);
    end
  end

  // Smallest n that fits
  always_comb begin
    count = 5'd16;
    for (int n = 16; n >= 1; n--) begin
      if (fits[n-1]) begin
        count = 5'(n);
      end
    end
  end

  // Left-align: shift up by the unused bytes, four byte-shift levels
  assign shift_bytes = 4'(5'd16 - count);

  always_comb begin
    shifted = value;
    for (int i = 0; i < 4; i++) begin
      if (shift_bytes[i]) begin
        shifted = shifted << (8 * (1 << i));
      end
    end
  end

  assign enc.count = count;
  assign enc.bytes = shifted;

endmodule

`default_nettype wire

// ===== src/dfse_checker.sv =====
// Port-level checks for decimal_field_slot_encoder, attached by bind.
// Depends on dfse_pkg for the bus widths.
`default_nettype none

module dfse_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic [dfse_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready
);
  import dfse_pkg::*;

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Null result carries no slot and no bytes
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[68:64] == 5'd0 &&
      m_axis_tdata[196:69] == 128'd0)
    else $error("null result with nonzero payload");

  // Wide result: count in range, slot holds count and cursor, cursor advanced by 16
  a_wide_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[68:64] != 5'd0 |->
      m_axis_tdata[68:64] <= 5'd16 && m_axis_tdata[4:0] == m_axis_tdata[68:64] &&
      {1'b0, m_axis_tdata[47:32]} + WIDE_SLOT_BYTES == m_axis_tdata[213:197])
    else $error("wide slot inconsistent with byte count or cursor");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind decimal_field_slot_encoder dfse_checker u_dfse_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for decimal_field_slot_encoder: drives random and directed decimals
// through the stream ports and checks every result. Depends on dfse_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import dfse_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 228;

  // Expected contents of one output transaction
  typedef struct packed {
    logic [63:0] slot_word;
    logic [4:0]  byte_count;
    logic [63:0] bytes_upper;
    logic [63:0] bytes_lower;
    logic [16:0] next_cursor;
    logic        null_flag;
  } slot_result_t;

  // Predicts slot encodings and matches them against the block's output
  class dfse_scoreboard;
    slot_result_t expected_q[$];
    logic [5:0]   precision;
    int           errors;

    function new();
      precision = PRECISION_RESET;
      errors    = 0;
    endfunction

    function void set_precision(logic [5:0] p);
      precision = p;
    endfunction

    // Minimal two's-complement byte string, or the inline long form
    function slot_result_t encode_slot(logic [127:0] val, logic nul, logic [15:0] cur);
      slot_result_t r;
      logic [127:0] mag;
      logic [127:0] aligned;
      logic         wide;
      int           bits;
      int           nbytes;
      r    = '0;
      wide = precision > INLINE_MAX_PRECISION;
      r.next_cursor = wide ? {1'b0, cur} + WIDE_SLOT_BYTES : {1'b0, cur};
      r.null_flag   = nul;
      if (!nul) begin
        if (wide) begin
          mag  = val[127] ? ~val : val;
          bits = 0;
          for (int i = 0; i < 128; i++) begin
            if (mag[i]) bits = i + 1;
          end
          nbytes        = bits / 8 + 1;
          aligned       = val << (8 * (16 - nbytes));
          r.byte_count  = 5'(nbytes);
          r.bytes_upper = aligned[127:64];
          r.bytes_lower = aligned[63:0];
          r.slot_word   = (64'(cur) << CURSOR_SHIFT) | 64'(nbytes);
        end else begin
          r.slot_word = val[63:0];
        end
      end
      return r;
    endfunction

    function void note_input(logic [127:0] val, logic nul, logic [15:0] cur);
      expected_q.insert(expected_q.size(), encode_slot(val, nul, cur));
    endfunction

    function void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %h, got %h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic flag);
      slot_result_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with no prediction waiting");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("slot_word",   e.slot_word,          data[63:0]);
      check_field("byte_count",  64'(e.byte_count),    64'(data[68:64]));
      check_field("bytes_upper", e.bytes_upper,        data[132:69]);
      check_field("bytes_lower", e.bytes_lower,        data[196:133]);
      check_field("next_cursor", 64'(e.next_cursor),   64'(data[213:197]));
      check_field("null_flag",   64'(e.null_flag),     64'(flag));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [5:0]            cfg_data = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;

  logic                  bursts_on = 1'b1;
  int                    stall_left = 0;
  int                    cycle_count = 0;
  dfse_scoreboard        sb = new();

  decimal_field_slot_encoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Record accepted transactions on every channel
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_precision(cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input({s_axis_tdata[63:0], s_axis_tdata[127:64]}, s_axis_tuser,
                      s_axis_tdata[143:128]);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // Output backpressure in bursts of random length
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Present one decimal and hold it until the transaction completes
  task automatic send_decimal(input logic [127:0] val, input logic nul, input logic [15:0] cur);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tdata  <= {cur, val[63:0], val[127:64]};
    s_axis_tuser  <= nul;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted result has been seen
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_precision(input logic [5:0] p);
    drain_results();
    cfg_data  <= p;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Values spread over all byte lengths, both signs and powers of two
  function automatic logic [127:0] rand_decimal();
    logic [127:0] v;
    int           k;
    int           s;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 5))
      1, 2, 3: begin
        k = $urandom_range(1, 127);
        v = v >> (128 - k);
        v[k-1] = 1'b1;
        if ($urandom_range(0, 1) == 1) v = ~v;
      end
      4: begin
        v = 128'd1 << $urandom_range(0, 126);
        case ($urandom_range(0, 2))
          0: v = -v;
          1: v = v - 128'd1;
          default: ;
        endcase
      end
      5: begin
        s = $urandom_range(0, 600) - 300;
        v = {{96{s[31]}}, s};
      end
      default: ;
    endcase
    return v;
  endfunction

  logic [5:0] phase_prec [8];

  initial begin
    phase_prec = '{6'd19, 6'd63, 6'd1, 6'd18, 6'd0, 6'd38, 6'd25, 6'($urandom_range(0, 63))};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Wide form at reset precision: length boundaries and sign extremes
    send_decimal(128'd0, 1'b0, 16'h0000);
    send_decimal({128{1'b1}}, 1'b0, 16'h0001);
    send_decimal(128'd1, 1'b0, 16'h1234);
    send_decimal(128'd127, 1'b0, 16'h8000);
    send_decimal(128'd128, 1'b0, 16'h0010);
    send_decimal(-128'sd128, 1'b0, 16'h00F0);
    send_decimal(-128'sd129, 1'b0, 16'h0F00);
    send_decimal({1'b0, {127{1'b1}}}, 1'b0, 16'hFFFF);
    send_decimal({1'b1, 127'd0}, 1'b0, 16'hFFFF);   // most negative value
    send_decimal({{64{1'b1}}, 64'd0}, 1'b0, 16'h0100); // negative power of two
    send_decimal({64'd0, 1'b1, 63'd0}, 1'b0, 16'h5555);
    send_decimal({{65{1'b1}}, 63'd0}, 1'b0, 16'hAAAA);
    send_decimal({64'd0, {64{1'b1}}}, 1'b0, 16'h0002);
    send_decimal(128'd255, 1'b0, 16'h7FFF);
    send_decimal(128'h7F_FFFF_FFFF_FFFF_FFFF, 1'b1, 16'hFFFF); // null in wide mode
    send_decimal(128'd5, 1'b1, 16'h0000);

    // Inline form at the top of its range
    write_precision(6'd18);
    send_decimal({64'hDEAD_BEEF_0123_4567, 64'h89AB_CDEF_FEDC_BA98}, 1'b0, 16'hFFFF);
    send_decimal({128{1'b1}}, 1'b0, 16'h0000);
    send_decimal(128'd42, 1'b1, 16'h4321);

    // Precision outside the nominal range on both ends
    write_precision(6'd0);
    send_decimal({1'b1, 127'd0}, 1'b0, 16'hFFFF);
    send_decimal(128'd7, 1'b1, 16'hFFFF);
    write_precision(6'd63);
    send_decimal({1'b1, 127'd0}, 1'b0, 16'hFFFF);
    send_decimal(128'd0, 1'b1, 16'hFFFF);

    // Random phases, one precision each; the last runs without idling
    for (int p = 0; p < 8; p++) begin
      write_precision(phase_prec[p]);
      bursts_on <= (p == 7) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_decimal(rand_decimal(), $urandom_range(0, 7) == 0, 16'($urandom));
    end

    drain_results();
    if (sb.expected_q.size() != 0)
      $error("%0d predicted results never arrived", sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
